// File: rtl/binary_max_heap_queue_defines.svh
// ----------------------------------------------------------------------------
// binary max heap queue assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MAX_HEAP_QUEUE_DEFINES_SVH

// property holds at every edge
`define BHQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds at the edge after the antecedent
`define BHQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bhq_pkg.sv
// ----------------------------------------------------------------------------
// bhq_pkg
// field widths, operation and status codes, cell control type
// ----------------------------------------------------------------------------
package bhq_pkg;

  localparam int FUNC_W   = 1;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic insert;
    logic remove;
  } bhq_ctrl_t;

endpackage

// File: rtl/bhq_in_if.sv
// ----------------------------------------------------------------------------
// bhq_in_if
// operation channel: insert or remove-max request beats
// ----------------------------------------------------------------------------
interface bhq_in_if;
  import bhq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);

endinterface

// File: rtl/bhq_out_if.sv
// ----------------------------------------------------------------------------
// bhq_out_if
// result channel: one beat per operation
// ----------------------------------------------------------------------------
interface bhq_out_if;
  import bhq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] removed_value;
  logic signed [VALUE_W-1:0] top_value;
  logic [COUNT_W-1:0]        count;
  logic                      is_empty;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, removed_value, top_value, count, is_empty, status,
                  input ready);
  modport sink   (input valid, removed_value, top_value, count, is_empty, status,
                  output ready);

endinterface

// File: rtl/bhq_cell.sv
// ----------------------------------------------------------------------------
// bhq_cell
// one slot of the sorted key chain; keys run from largest at cell zero
// ----------------------------------------------------------------------------
module bhq_cell #(
  parameter int KEY_WIDTH = 32
) (
  input  logic                        clk_i,
  input  bhq_pkg::bhq_ctrl_t          ctrl_i,
  input  logic                        occupied_i,
  input  logic signed [KEY_WIDTH-1:0] new_key_i,
  input  logic signed [KEY_WIDTH-1:0] left_key_i,
  input  logic                        left_keep_i,
  input  logic signed [KEY_WIDTH-1:0] right_key_i,
  output logic signed [KEY_WIDTH-1:0] key_o,
  output logic signed [KEY_WIDTH-1:0] next_key_o,
  output logic                        keep_o
);
  import bhq_pkg::*;

  logic signed [KEY_WIDTH-1:0] key_q;
  logic signed [KEY_WIDTH-1:0] key_d;

  // own key not smaller than the incoming one: stays put
  assign keep_o = occupied_i && !(key_q < new_key_i);

  always_comb begin
    key_d = key_q;
    if (ctrl_i.insert) begin
      if (keep_o) begin
        key_d = key_q;
      end else if (left_keep_i) begin
        key_d = new_key_i;
      end else begin
        key_d = left_key_i;
      end
    end else if (ctrl_i.remove) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o      = key_q;
  assign next_key_o = key_d;

endmodule

// File: rtl/binary_max_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// max-priority queue of signed keys in a row of sorted cells
//
//   channel | dir | beat contents
//   in_i    | in  | func, value
//   out_o   | out | removed_value, top_value, count, is_empty, status
//
// one operation per cycle while no result is held: the cell row shifts or
// inserts at once, each cell comparing its key with the new one and its left
// neighbour's result; the result beat reaches the output register next cycle
// reset clears the entry count and the output valid; cells hold no reset
// a held result stalls the input until out_o takes it
// ----------------------------------------------------------------------------
module binary_max_heap_queue #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bhq_in_if.sink    in_i,
  bhq_out_if.source out_o
);
  import bhq_pkg::*;

`include "binary_max_heap_queue_defines.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  logic             in_fire, full, empty, do_ins, do_rem;
  logic             is_ins, is_rem;
  bhq_ctrl_t        ctrl;

  logic signed [KEY_WIDTH-1:0] new_key;
  logic signed [KEY_WIDTH-1:0] cell_key  [CAPACITY];
  logic signed [KEY_WIDTH-1:0] cell_next [CAPACITY];
  logic                        cell_keep [CAPACITY];

  logic signed [VALUE_W-1:0] removed_d, removed_q;
  logic signed [VALUE_W-1:0] top_d, top_q;
  logic [STATUS_W-1:0]       status_d, status_q;
  logic [COUNT_W-1:0]        count_out_q;
  logic                      empty_out_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign full       = count_q == CNT_W'(CAPACITY);
  assign empty      = count_q == '0;
  assign is_ins     = in_i.func == FUNC_INSERT;
  assign is_rem     = in_i.func == FUNC_REMOVE;
  assign do_ins     = in_fire && is_ins && !full;
  assign do_rem     = in_fire && is_rem && !empty;
  assign new_key    = KEY_WIDTH'(in_i.value);

  assign ctrl.insert = do_ins;
  assign ctrl.remove = do_rem;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_WIDTH-1:0] left_key, right_key;
    logic                        left_keep;

    if (i == 0) begin : g_head
      assign left_key  = new_key;
      assign left_keep = 1'b0;
    end else begin : g_body
      assign left_key  = cell_key[i-1];
      assign left_keep = cell_keep[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_key = cell_key[i];
    end else begin : g_mid
      assign right_key = cell_key[i+1];
    end

    bhq_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (count_q > CNT_W'(i)),
      .new_key_i   (new_key),
      .left_key_i  (left_key),
      .left_keep_i (left_keep),
      .right_key_i (right_key),
      .key_o       (cell_key[i]),
      .next_key_o  (cell_next[i]),
      .keep_o      (cell_keep[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    status_d = STATUS_OK;
    if (is_ins && full) begin
      status_d = STATUS_FULL;
    end else if (is_rem && empty) begin
      status_d = STATUS_EMPTY;
    end
  end

  assign removed_d = do_rem ? VALUE_W'(cell_key[0]) : '0;
  assign top_d     = (count_d != '0) ? VALUE_W'(cell_next[0]) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      removed_q   <= removed_d;
      top_q       <= top_d;
      status_q    <= status_d;
      count_out_q <= COUNT_W'(count_d);
      empty_out_q <= count_d == '0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.removed_value = removed_q;
  assign out_o.top_value     = top_q;
  assign out_o.count         = count_out_q;
  assign out_o.is_empty      = empty_out_q;
  assign out_o.status        = status_q;

  `BHQ_ASSERT(count_bound_a, count_q <= CNT_W'(CAPACITY), "entry count past capacity")
  `BHQ_ASSERT(head_order_a, (count_q >= CNT_W'(2)) |-> (cell_key[0] >= cell_key[1]), "head not max")
  `BHQ_ASSERT_NEXT(remove_count_a, do_rem, count_q == $past(count_q) - CNT_W'(1), "no count drop")
  `BHQ_ASSERT_NEXT(refused_hold_a, in_fire && !do_ins && !do_rem, $stable(count_q), "count changed")

endmodule

// File: dv/bhq_heap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhq_heap_checker
// watches the operation and result channels of the heap queue, keeps its own
// max heap of the accepted keys and compares every result beat, field by
// field, with the oldest predicted queue view
// ----------------------------------------------------------------------------
module bhq_heap_checker #(
  parameter int CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bhq_in_if           op_i,
  bhq_out_if          res_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);
  import bhq_pkg::*;

  typedef struct packed {
    logic signed [VALUE_W-1:0] removed_value;
    logic signed [VALUE_W-1:0] top_value;
    logic [COUNT_W-1:0]        count;
    logic                      is_empty;
    logic [STATUS_W-1:0]       status;
  } queue_view_t;

  logic signed [VALUE_W-1:0] heap_keys [CAPACITY];
  int                        held;
  queue_view_t               expected_views [$];

  function automatic void swap_keys(int a, int b);
    logic signed [VALUE_W-1:0] tmp;
    tmp          = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = tmp;
  endfunction

  function automatic queue_view_t apply_heap_op(logic [FUNC_W-1:0] func,
                                                logic signed [VALUE_W-1:0] key);
    queue_view_t view;
    int          pos;
    int          up;
    int          left;
    int          right;
    int          best;
    view        = '0;
    view.status = STATUS_OK;
    if (func == FUNC_INSERT) begin
      if (held >= CAPACITY) begin
        view.status = STATUS_FULL;
      end else begin
        heap_keys[held] = key;
        pos             = held;
        held++;
        // sift up, stop on equal keys
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_keys[up] >= heap_keys[pos]) break;
          swap_keys(up, pos);
          pos = up;
        end
      end
    end else if (held == 0) begin
      view.status = STATUS_EMPTY;
    end else begin
      view.removed_value = heap_keys[0];
      held--;
      if (held > 0) begin
        heap_keys[0] = heap_keys[held];
        pos          = 0;
        // sift down, left child wins a tie
        forever begin
          left  = 2 * pos + 1;
          right = left + 1;
          best  = pos;
          if (left < held && heap_keys[best] < heap_keys[left]) best = left;
          if (right < held && heap_keys[best] < heap_keys[right]) best = right;
          if (best == pos) break;
          swap_keys(pos, best);
          pos = best;
        end
      end
    end
    view.top_value = (held > 0) ? heap_keys[0] : '0;
    view.count     = COUNT_W'(held);
    view.is_empty  = (held == 0);
    return view;
  endfunction

  task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d (0x%h), actual %0d (0x%h)",
               $time, name, $signed(want), want, $signed(got), got);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    queue_view_t want;
    if (!rst_ni) begin
      held             = 0;
      mismatch_count_o = 0;
      expected_views.delete();
    end else begin
      if (op_i.valid && op_i.ready) begin
        expected_views = {expected_views, apply_heap_op(op_i.func, op_i.value)};
      end
      if (res_i.valid && res_i.ready) begin
        if (expected_views.size() == 0) begin
          $display("%0t: expected no result beat, actual removed %0d top %0d count %0d",
                   $time, res_i.removed_value, res_i.top_value, res_i.count);
          mismatch_count_o++;
        end else begin
          want = expected_views.pop_front();
          check_field("removed_value", want.removed_value, res_i.removed_value);
          check_field("top_value", want.top_value, res_i.top_value);
          check_field("count", VALUE_W'(want.count), VALUE_W'(res_i.count));
          check_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(res_i.is_empty));
          check_field("status", VALUE_W'(want.status), VALUE_W'(res_i.status));
        end
      end
    end
    pending_o = expected_views.size();
  end

endmodule

// File: dv/tb_binary_max_heap_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_max_heap_queue
// drives insert and remove-max beats into the heap queue: a directed opening
// over extreme, equal and refused cases, then phases leaning to insert or to
// remove so the queue fills and drains repeatedly, with random idling on both
// channels and long result hold-offs; the checker judges every result beat
// ----------------------------------------------------------------------------
module tb_binary_max_heap_queue;
  import bhq_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int RANDOM_ITEMS = 850;
  localparam int HOLD_CYCLES  = 400;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatches;
  int unsigned in_flight;
  bit          idle_on = 1'b1;
  logic        hold_req;

  bhq_in_if  op_ch ();
  bhq_out_if res_ch ();

  binary_max_heap_queue #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(VALUE_W)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (op_ch),
    .out_o (res_ch)
  );

  bhq_heap_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op_ch),
    .res_i           (res_ch),
    .mismatch_count_o(mismatches),
    .pending_o       (in_flight)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_op(logic [FUNC_W-1:0] func, logic signed [VALUE_W-1:0] key);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      op_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    op_ch.valid <= 1'b1;
    op_ch.func  <= func;
    op_ch.value <= key;
    @(posedge clk_i);
    while (!op_ch.ready) @(posedge clk_i);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_key(logic signed [VALUE_W-1:0] last);
    case ($urandom_range(0, 9))
      6, 7:    return VALUE_W'($signed($urandom_range(0, 15)) - 8);
      8: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7fff_ffff;
          1:       return 32'sh8000_0000;
          2:       return '0;
          default: return '1;
        endcase
      end
      9:       return last;
      default: return $urandom;
    endcase
  endfunction

  // result side: random stalls, plus a long hold-off on request
  initial begin : result_taker
    int gap_left;
    int hold_left;
    gap_left  = 0;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req === 1'b1) begin
        hold_req  <= 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (!idle_on) begin
        res_ch.ready <= 1'b1;
      end else if (gap_left > 0) begin
        res_ch.ready <= 1'b0;
        gap_left--;
      end else begin
        res_ch.ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 17);
      end
    end
  end

  initial begin : stimulus
    int                        n_items;
    int                        phase;
    int                        phase_len;
    int                        insert_pct;
    logic signed [VALUE_W-1:0] last_key;
    logic signed [VALUE_W-1:0] key;
    rst_ni      <= 1'b0;
    hold_req    <= 1'b0;
    op_ch.valid <= 1'b0;
    op_ch.func  <= FUNC_INSERT;
    op_ch.value <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // refused remove, extremes, equal keys, then drain past empty
    send_op(FUNC_REMOVE, $urandom);
    send_op(FUNC_INSERT, '0);
    send_op(FUNC_INSERT, 32'sh7fff_ffff);
    send_op(FUNC_INSERT, 32'sh8000_0000);
    send_op(FUNC_INSERT, '1);
    send_op(FUNC_INSERT, 32'sd1);
    send_op(FUNC_INSERT, 32'sh7fff_ffff);
    repeat (3) send_op(FUNC_INSERT, 32'sd5);
    repeat (10) send_op(FUNC_REMOVE, $urandom);
    send_op(FUNC_REMOVE, '1);

    n_items  = 0;
    phase    = 0;
    last_key = '0;
    while (n_items < RANDOM_ITEMS) begin
      phase_len  = $urandom_range(90, 150);
      insert_pct = (phase % 2 == 0) ? 85 : 15;
      for (int i = 0; i < phase_len && n_items < RANDOM_ITEMS; i++) begin
        if (n_items == 300 || n_items == 600) hold_req <= 1'b1;
        if (n_items >= RANDOM_ITEMS - 100) idle_on = 1'b0;
        key = pick_key(last_key);
        if ($urandom_range(1, 100) <= insert_pct) begin
          send_op(FUNC_INSERT, key);
          last_key = key;
        end else begin
          send_op(FUNC_REMOVE, key);
        end
        n_items++;
      end
      phase++;
    end
    op_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (in_flight != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && in_flight == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
